### design/assert_macros.svh
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/sha256md_pkg.sv
package sha256md_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_t;

  localparam logic [7:0] PAD_MARKER = 8'h80;
  localparam logic [5:0] LEN_START  = 6'd56;
  localparam logic [5:0] BLOCK_LAST = 6'd63;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

### design/sha256_message_digest.sv
// SHA-256 streaming hasher, one message byte per request.
// Each full block goes through load, 64 rounds and fold.
// Closing request: pads one byte per cycle, then load/rounds/fold per block, then 8 words.
// No new message byte is taken while a block is hashed; requests stall until it is through.
// Reset (rst, synchronous, active high): initial hash, empty buffer, length zero, idle.
module sha256_message_digest (
  input  logic        clk,
  input  logic        rst,
  // message request channel
  input  logic        msg_valid,
  output logic        msg_stall,
  input  logic [7:0]  message_byte,
  input  logic        byte_present,
  input  logic        last_of_message,
  // digest request channel
  output logic        digest_valid,
  input  logic        digest_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha256md_pkg::*;

  // Sequencer and control registers
  state_t      state, state_next;
  logic [5:0]  fill;          // bytes held in the current block
  logic [63:0] bit_length;    // message length in bits, wraps
  logic        pad_pending;   // closing request seen, padding still to do
  logic        marker_done;   // 0x80 byte already placed
  logic        len_ok;        // current block carries the length field
  logic [5:0]  round_cnt;
  logic [2:0]  out_idx;

  // Datapath registers
  logic [23:0] acc;           // partial big-endian word being packed
  logic [31:0] window [16];   // block words, then the message schedule
  logic [31:0] work   [8];    // a..h
  logic [31:0] hash   [8];    // chaining value

  logic        msg_take;
  logic        digest_take;
  logic        ins_en;
  logic [7:0]  ins_byte;
  logic        push_word;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  // Round datapath
  logic [31:0] big_s0, big_s1, ch, maj, t1, t2;
  logic [31:0] sm_s0, sm_s1, w_new;

  always_comb begin
    big_s1 = rotr(work[4], 6) ^ rotr(work[4], 11) ^ rotr(work[4], 25);
    ch     = (work[4] & work[5]) ^ (~work[4] & work[6]);
    t1     = work[7] + big_s1 + ch + ROUND_K[round_cnt] + window[0];
    big_s0 = rotr(work[0], 2) ^ rotr(work[0], 13) ^ rotr(work[0], 22);
    maj    = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
    t2     = big_s0 + maj;
    // schedule: window holds W[r..r+15]; produce W[r+16]
    sm_s0  = rotr(window[1], 7) ^ rotr(window[1], 18) ^ (window[1] >> 3);
    sm_s1  = rotr(window[14], 17) ^ rotr(window[14], 19) ^ (window[14] >> 10);
    w_new  = sm_s1 + window[9] + sm_s0 + window[0];
  end

  // Byte insertion: a message byte when idle, a padding byte in ST_PAD.
  always_comb begin
    msg_take    = msg_valid && !msg_stall;
    digest_take = digest_valid && !digest_stall;
    ins_en      = (msg_take && byte_present) || (state == ST_PAD);
    if (state != ST_PAD) begin
      ins_byte = message_byte;
    end else if (!marker_done) begin
      ins_byte = PAD_MARKER;
    end else if (len_ok && fill >= LEN_START) begin
      // big-endian length: byte 56 is bits 63:56
      ins_byte = bit_length[{~fill[2:0], 3'b000} +: 8];
    end else begin
      ins_byte = 8'h00;
    end
    push_word = ins_en && (fill[1:0] == 2'b11);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (msg_take) begin
          if (byte_present && fill == BLOCK_LAST) begin
            state_next = ST_LOAD;
          end else if (last_of_message) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (fill == BLOCK_LAST) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD:  state_next = ST_ROUND;
      ST_ROUND: begin
        if (round_cnt == BLOCK_LAST) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (marker_done && len_ok) begin
          state_next = ST_OUT;
        end else if (marker_done || pad_pending) begin
          state_next = ST_PAD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (digest_take && out_idx == 3'd7) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake and result outputs
  always_comb begin
    msg_stall    = (state != ST_IDLE);
    digest_valid = (state == ST_OUT);
    digest_word  = hash[out_idx];
    word_index   = out_idx;
    last_word    = (out_idx == 3'd7);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      fill        <= '0;
      bit_length  <= '0;
      pad_pending <= 1'b0;
      marker_done <= 1'b0;
      len_ok      <= 1'b0;
      round_cnt   <= '0;
      out_idx     <= '0;
    end else begin
      state <= state_next;
      if (ins_en) begin
        fill <= fill + 6'd1;  // wraps to 0 on a full block
      end
      if (msg_take && byte_present) begin
        bit_length <= bit_length + 64'd8;
      end
      if (msg_take && last_of_message) begin
        pad_pending <= 1'b1;
      end
      if (state == ST_PAD && !marker_done) begin
        marker_done <= 1'b1;
        len_ok      <= (fill < LEN_START);
      end
      // an extra block always carries the length
      if (state == ST_FOLD && marker_done) begin
        len_ok <= 1'b1;
      end
      if (state == ST_ROUND) begin
        round_cnt <= round_cnt + 6'd1;
      end
      if (digest_take) begin
        out_idx <= out_idx + 3'd1;
        if (out_idx == 3'd7) begin
          // start the next message
          bit_length  <= '0;
          pad_pending <= 1'b0;
          marker_done <= 1'b0;
          len_ok      <= 1'b0;
        end
      end
    end
  end

  // Chaining value
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        hash[i] <= INIT_HASH[i];
      end
    end else if (state == ST_FOLD) begin
      for (int i = 0; i < 8; i++) begin
        hash[i] <= hash[i] + work[i];
      end
    end else if (digest_take && out_idx == 3'd7) begin
      for (int i = 0; i < 8; i++) begin
        hash[i] <= INIT_HASH[i];
      end
    end
  end

  // Packing, schedule window and working words
  always_ff @(posedge clk) begin
    if (ins_en) begin
      acc <= {acc[15:0], ins_byte};
    end
    if (push_word) begin
      for (int i = 0; i < 15; i++) begin
        window[i] <= window[i + 1];
      end
      window[15] <= {acc, ins_byte};
    end else if (state == ST_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        window[i] <= window[i + 1];
      end
      window[15] <= w_new;
    end
    if (state == ST_LOAD) begin
      for (int i = 0; i < 8; i++) begin
        work[i] <= hash[i];
      end
    end else if (state == ST_ROUND) begin
      work[7] <= work[6];
      work[6] <= work[5];
      work[5] <= work[4];
      work[4] <= work[3] + t1;
      work[3] <= work[2];
      work[2] <= work[1];
      work[1] <= work[0];
      work[0] <= t1 + t2;
    end
  end

endmodule

### design/sha256md_checker.sv
`include "assert_macros.svh"

module sha256md_checker (
  input logic        clk,
  input logic        rst,
  input logic        msg_stall,
  input logic        digest_valid,
  input logic        digest_stall,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        last_word
);

  // nothing comes out right after reset
  `ASSERT_ALWAYS(a_idle_after_rst, clk, rst |=> !digest_valid, "digest valid after reset")

  // hasher takes no message byte while a digest is going out
  `ASSERT_CLK(a_busy_out, clk, rst, digest_valid |-> msg_stall, "message taken during output")

  // last flag marks word seven only
  `ASSERT_CLK(a_last_flag, clk, rst, digest_valid |-> (last_word == (word_index == 3'd7)),
              "last_word does not match index")

  // words follow one another without gaps in index
  `ASSERT_CLK(a_word_order, clk, rst,
              (digest_valid && !digest_stall && !last_word) |=>
              (digest_valid && word_index == $past(word_index) + 3'd1),
              "digest words out of order")

  // stalled digest word holds
  `ASSERT_CLK(a_hold, clk, rst,
              (digest_valid && digest_stall) |=> (digest_valid && $stable(digest_word)),
              "stalled digest word changed")

endmodule

bind sha256_message_digest sha256md_checker u_sha256md_checker (.*);

### test/sha256_message_digest_tb.sv
`timescale 1ns / 1ps

module sha256_message_digest_tb;

  // Round constants and initial chaining words of SHA-256, kept apart from the
  // RTL package so that a wrong table in the RTL cannot hide itself.
  localparam logic [31:0] ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] START_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Well-known digests, h0 in the top bits.
  localparam logic [255:0] EMPTY_DIGEST =
    256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
  localparam logic [255:0] ABC_DIGEST =
    256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

  // Directed request table. known=1 rows carry the digest typed in; the
  // rest are checked against the local hash model.
  typedef struct packed {
    logic [7:0]   data;
    logic         present;
    logic         last;
    logic         known;
    logic [255:0] digest;
  } stim_row_t;

  localparam int N_DIRECTED = 12;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},  // empty message
    '{8'h5a, 1'b0, 1'b0, 1'b0, 256'h0},        // no byte, no last: ignored
    '{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},        // "abc", last rides on the byte
    '{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
    '{8'h00, 1'b1, 1'b1, 1'b0, 256'h0},        // lowest byte alone
    '{8'hff, 1'b1, 1'b1, 1'b0, 256'h0},        // highest byte alone
    '{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'hc3, 1'b0, 1'b0, 1'b0, 256'h0},        // ignored request mid-message
    '{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 256'h0},        // empty closing request
    '{8'hff, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST}   // byte field set but not present
  };

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        is_last;
  } digest_entry_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        msg_valid = 1'b0;
  logic        msg_stall;
  logic [7:0]  message_byte = 8'h00;
  logic        byte_present = 1'b0;
  logic        last_of_message = 1'b0;
  logic        digest_valid;
  logic        digest_stall = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  // Hash model state.
  logic [31:0] chain_h [8];
  logic [7:0]  blk_bytes [64];
  int          blk_fill;
  logic [63:0] msg_bits;
  logic [31:0] digest_out [8];

  digest_entry_t pending_words [$];
  int            mismatches = 0;
  int            requests_taken = 0;
  int            words_seen = 0;

  always #10 clk = ~clk;

  sha256_message_digest u_top (
    .clk             (clk),
    .rst             (rst),
    .msg_valid       (msg_valid),
    .msg_stall       (msg_stall),
    .message_byte    (message_byte),
    .byte_present    (byte_present),
    .last_of_message (last_of_message),
    .digest_valid    (digest_valid),
    .digest_stall    (digest_stall),
    .digest_word     (digest_word),
    .word_index      (word_index),
    .last_word       (last_word)
  );

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void hash_restart();
    for (int j = 0; j < 8; j++) chain_h[j] = START_HASH[j];
    blk_fill = 0;
    msg_bits = 64'd0;
  endfunction

  // One 64-round compression of blk_bytes into chain_h. Uses the full
  // 64-entry schedule rather than a rolling window; same values.
  function automatic void hash_compress();
    logic [31:0] sched [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int j = 0; j < 16; j++)
      sched[j] = {blk_bytes[4*j], blk_bytes[4*j+1], blk_bytes[4*j+2], blk_bytes[4*j+3]};
    for (int j = 16; j < 64; j++)
      sched[j] = (rotr(sched[j-2], 17) ^ rotr(sched[j-2], 19) ^ (sched[j-2] >> 10))
               + sched[j-7]
               + (rotr(sched[j-15], 7) ^ rotr(sched[j-15], 18) ^ (sched[j-15] >> 3))
               + sched[j-16];
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
    e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
    for (int r = 0; r < 64; r++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + ROUND_CONST[r] + sched[r];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
    chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
  endfunction

  // Absorbs one request; returns 1 when it closed the message, with the
  // digest left in digest_out and the model ready for the next message.
  function automatic bit hash_absorb(logic [7:0] data, logic present, logic last);
    if (present) begin
      blk_bytes[blk_fill] = data;
      blk_fill++;
      msg_bits += 64'd8;
      if (blk_fill == 64) begin
        hash_compress();
        blk_fill = 0;
      end
    end
    if (!last) return 1'b0;
    blk_bytes[blk_fill] = 8'h80;
    blk_fill++;
    // No room left for the length field: spill into an extra block.
    if (blk_fill > 56) begin
      while (blk_fill < 64) blk_bytes[blk_fill++] = 8'h00;
      hash_compress();
      blk_fill = 0;
    end
    while (blk_fill < 56) blk_bytes[blk_fill++] = 8'h00;
    for (int j = 0; j < 8; j++) blk_bytes[56 + j] = msg_bits[63 - 8*j -: 8];
    hash_compress();
    for (int j = 0; j < 8; j++) digest_out[j] = chain_h[j];
    hash_restart();
    return 1'b1;
  endfunction

  // Drive one request and hold it until taken. Sender idles at random,
  // except across a calm stretch of requests. msg_valid is left high on
  // return; the next call or the end of stimulus decides its next value.
  task automatic put_request(logic [7:0] data, logic present, logic last,
                             logic known = 1'b0, logic [255:0] typed_digest = '0);
    bit closed;
    while (!(requests_taken >= 40 && requests_taken < 100) && $urandom_range(99) < 17) begin
      msg_valid <= 1'b0;
      @(posedge clk);
    end
    msg_valid       <= 1'b1;
    message_byte    <= data;
    byte_present    <= present;
    last_of_message <= last;
    do @(posedge clk); while (msg_stall);
    requests_taken++;
    closed = hash_absorb(data, present, last);
    if (closed)
      for (int j = 0; j < 8; j++)
        pending_words.push_back('{known ? typed_digest[255 - 32*j -: 32] : digest_out[j],
                                  3'(j), j == 7});
  endtask

  // Well-formed message of len bytes with random content; ignored requests
  // sprinkled in, and the close either on the final byte or on its own.
  task automatic put_message(int len);
    bit tail_close;
    tail_close = (len == 0) || ($urandom_range(1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) put_request(8'($urandom), 1'b0, 1'b0);
      put_request(8'($urandom), 1'b1, (i == len - 1) && !tail_close);
    end
    if (tail_close) put_request(8'($urandom), 1'b0, 1'b1);
  endtask

  // Digest side: random stall, with a calm stretch of words; every taken
  // word is matched against the oldest pending one.
  always @(posedge clk) begin : digest_sink
    digest_entry_t want;
    if (rst) begin
      digest_stall <= 1'b0;
    end else begin
      if (digest_valid && !digest_stall) begin
        words_seen++;
        if (pending_words.size() == 0) begin
          $error("digest word with none pending: digest_word %h word_index %0d",
                 digest_word, word_index);
          mismatches++;
        end else begin
          want = pending_words.pop_front();
          if (digest_word !== want.word) begin
            $error("digest_word: expected %h, actual %h", want.word, digest_word);
            mismatches++;
          end
          if (word_index !== want.index) begin
            $error("word_index: expected %0d, actual %0d", want.index, word_index);
            mismatches++;
          end
          if (last_word !== want.is_last) begin
            $error("last_word: expected %0b, actual %0b", want.is_last, last_word);
            mismatches++;
          end
        end
      end
      digest_stall <= (words_seen >= 16 && words_seen < 40) ? 1'b0
                                                            : ($urandom_range(99) < 17);
    end
  end

  initial begin : stimulus
    // Block-boundary lengths: 56 forces a padding-only block, 64 fills a
    // block before the close. Both carry random content.
    int boundary_len [2];
    int first;
    boundary_len = '{56, 64};
    first = $urandom_range(1);
    hash_restart();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++)
      put_request(DIRECTED[i].data, DIRECTED[i].present, DIRECTED[i].last,
                  DIRECTED[i].known, DIRECTED[i].digest);

    // Random messages at both boundary lengths, in random order.
    put_message(boundary_len[first]);
    put_message(boundary_len[1 - first]);
    msg_valid <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    // Room for any stray word after the last expected one.
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("sha256_message_digest: match");
    end else begin
      $display("sha256_message_digest: mismatch");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin : watchdog
    #5_000_000;
    $display("sha256_message_digest: mismatch");
    $finish;
  end

endmodule
